>>> rtl/core/fwcs_pkg.sv
// fwcs_pkg: shared widths, codes and the queue entry type of the flash
// write command splitter. No dependencies.
`timescale 1ns / 1ps

package fwcs_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned LEN_W = 21;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned KIND_W = 2;

  localparam int unsigned MAX_WRITE_BYTES_DEF = 1048576;

  // depth of the queue between front and back
  localparam int unsigned QDEPTH = 2;

  localparam logic [WORD_W-1:0] PAD_WORD = 32'hFFFF_FFFF;

  // output command codes
  localparam logic [KIND_W-1:0] CMD_WORD = 2'd0;
  localparam logic [KIND_W-1:0] CMD_QUAD = 2'd1;
  localparam logic [KIND_W-1:0] CMD_ERROR = 2'd2;

  // work handed from front to back
  typedef enum logic [2:0] {
    OP_WORD    = 3'd0,
    OP_QUAD    = 3'd1,
    OP_ERROR   = 3'd2,
    OP_GATHER  = 3'd3,
    OP_PARTIAL = 3'd4
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [ADDR_W-1:0]   addr;
    logic [WORD_W-1:0]   word;
    logic                fin;
    logic [1:0]          aux;   // gather slot, or bytes kept for a partial word
  } op_t;

endpackage

>>> rtl/core/fwcs_if.sv
// fwcs_if: valid/ready channel interfaces for source beats and commands.
// Depends on fwcs_pkg.
`timescale 1ns / 1ps

interface fwcs_in_if;
  logic                           valid;
  logic                           ready;
  logic                           first_word;
  logic [fwcs_pkg::ADDR_W-1:0]    start_address;
  logic [fwcs_pkg::LEN_W-1:0]     byte_length;
  logic [fwcs_pkg::WORD_W-1:0]    source_word;

  modport source (output valid, first_word, start_address, byte_length, source_word,
                  input ready);
  modport sink (input valid, first_word, start_address, byte_length, source_word,
                output ready);
endinterface

interface fwcs_out_if;
  logic                           valid;
  logic                           ready;
  logic [fwcs_pkg::KIND_W-1:0]    command_kind;
  logic [fwcs_pkg::ADDR_W-1:0]    program_address;
  logic [fwcs_pkg::WORD_W-1:0]    word_zero;
  logic [fwcs_pkg::WORD_W-1:0]    word_one;
  logic [fwcs_pkg::WORD_W-1:0]    word_two;
  logic [fwcs_pkg::WORD_W-1:0]    word_three;
  logic                           final_command;

  modport source (output valid, command_kind, program_address, word_zero, word_one,
                  word_two, word_three, final_command, input ready);
  modport sink (input valid, command_kind, program_address, word_zero, word_one,
                word_two, word_three, final_command, output ready);
endinterface

>>> rtl/core/fwcs_front.sv
// fwcs_front: accepts source beats, tracks address and length of the write
// and classifies each beat into a queue op. Depends on fwcs_pkg, fwcs_if.
`timescale 1ns / 1ps

module fwcs_front #(
  parameter int unsigned MAX_WRITE_BYTES = fwcs_pkg::MAX_WRITE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  fwcs_in_if.sink           in_ch,
  input  logic              q_ready,
  output logic              q_push,
  output fwcs_pkg::op_t     q_op
);

  localparam int unsigned LW = fwcs_pkg::LEN_W;
  localparam int unsigned AW = fwcs_pkg::ADDR_W;

  logic [LW-1:0] bytes_left_r, bytes_left_nxt;
  logic [AW-1:0] next_address_r, next_address_nxt;
  logic [1:0]    gathered_count_r, gathered_count_nxt;
  logic          write_active_r, write_active_nxt;
  logic          skipping_r, skipping_nxt;

  logic          accept;
  logic [LW-1:0] len_sat;
  logic [LW-1:0] bl;
  logic [AW-1:0] addr;
  logic [1:0]    gc;
  logic          go;
  logic [LW-1:0] bl_m4, bl_m16;

  assign in_ch.ready = q_ready;
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    if (32'(in_ch.byte_length) > 32'(MAX_WRITE_BYTES)) begin
      len_sat = LW'(MAX_WRITE_BYTES);
    end else begin
      len_sat = in_ch.byte_length;
    end
  end

  assign bl_m4  = bl - LW'(4);
  assign bl_m16 = bl - LW'(16);

  always_comb begin
    bytes_left_nxt     = bytes_left_r;
    next_address_nxt   = next_address_r;
    gathered_count_nxt = gathered_count_r;
    write_active_nxt   = write_active_r;
    skipping_nxt       = skipping_r;
    q_push             = 1'b0;
    q_op.kind          = fwcs_pkg::OP_WORD;
    q_op.addr          = next_address_r;
    q_op.word          = in_ch.source_word;
    q_op.fin           = 1'b0;
    q_op.aux           = 2'd0;
    bl                 = bytes_left_r;
    addr               = next_address_r;
    gc                 = gathered_count_r;
    go                 = 1'b0;

    if (accept) begin
      if (in_ch.first_word) begin
        gathered_count_nxt = 2'd0;
        if (in_ch.start_address[1:0] != 2'b00) begin
          write_active_nxt = 1'b0;
          skipping_nxt     = 1'b1;
          bytes_left_nxt   = '0;
          q_push           = 1'b1;
          q_op.kind        = fwcs_pkg::OP_ERROR;
          q_op.addr        = in_ch.start_address;
          q_op.fin         = 1'b1;
        end else begin
          skipping_nxt     = 1'b0;
          next_address_nxt = in_ch.start_address;
          bytes_left_nxt   = len_sat;
          write_active_nxt = (len_sat != '0);
          bl               = len_sat;
          addr             = in_ch.start_address;
          gc               = 2'd0;
          go               = (len_sat != '0);
        end
      end else begin
        go = write_active_r && !skipping_r;
      end
    end

    if (go) begin
      q_push    = 1'b1;
      q_op.addr = addr;
      if (gc == 2'd0 && addr[3:0] != 4'd0 && bl >= LW'(4)) begin
        // word programs up to the quadword boundary
        q_op.kind        = fwcs_pkg::OP_WORD;
        q_op.fin         = (bl_m4 == '0);
        bytes_left_nxt   = bl_m4;
        next_address_nxt = addr + AW'(4);
        write_active_nxt = (bl_m4 != '0);
      end else if (gc != 2'd0 || bl >= LW'(16)) begin
        if (gc != 2'd3) begin
          q_op.kind          = fwcs_pkg::OP_GATHER;
          q_op.aux           = gc;
          gathered_count_nxt = gc + 2'd1;
        end else begin
          q_op.kind          = fwcs_pkg::OP_QUAD;
          q_op.fin           = (bl_m16 == '0);
          gathered_count_nxt = 2'd0;
          bytes_left_nxt     = bl_m16;
          next_address_nxt   = addr + AW'(16);
          write_active_nxt   = (bl_m16 != '0);
        end
      end else if (bl >= LW'(4)) begin
        q_op.kind        = fwcs_pkg::OP_WORD;
        q_op.fin         = (bl_m4 == '0);
        bytes_left_nxt   = bl_m4;
        next_address_nxt = addr + AW'(4);
        write_active_nxt = (bl_m4 != '0);
      end else begin
        // one to three bytes left
        q_op.kind        = fwcs_pkg::OP_PARTIAL;
        q_op.fin         = 1'b1;
        q_op.aux         = bl[1:0];
        bytes_left_nxt   = '0;
        write_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r     <= '0;
      next_address_r   <= '0;
      gathered_count_r <= 2'd0;
      write_active_r   <= 1'b0;
      skipping_r       <= 1'b0;
    end else begin
      bytes_left_r     <= bytes_left_nxt;
      next_address_r   <= next_address_nxt;
      gathered_count_r <= gathered_count_nxt;
      write_active_r   <= write_active_nxt;
      skipping_r       <= skipping_nxt;
    end
  end

endmodule

>>> rtl/core/fwcs_queue.sv
// fwcs_queue: small fifo of ops between front and back.
// Depends on fwcs_pkg.
`timescale 1ns / 1ps

module fwcs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fwcs_pkg::op_t     push_op,
  output logic              ready,
  input  logic              pop,
  output logic              head_valid,
  output fwcs_pkg::op_t     head_op
);

  localparam int unsigned D  = fwcs_pkg::QDEPTH;
  localparam int unsigned PW = (D > 1) ? $clog2(D) : 1;
  localparam int unsigned CW = $clog2(D + 1);

  fwcs_pkg::op_t   mem_r [D];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign ready      = (count_r != CW'(D));
  assign head_valid = (count_r != '0);
  assign head_op    = mem_r[rptr_r];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(D - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  always_comb begin
    wptr_nxt  = push ? ptr_inc(wptr_r) : wptr_r;
    rptr_nxt  = pop ? ptr_inc(rptr_r) : rptr_r;
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

>>> rtl/core/fwcs_back.sv
// fwcs_back: drains queue ops, gathers quadword data, pads partial words
// and holds the command output register. Depends on fwcs_pkg, fwcs_if.
`timescale 1ns / 1ps

module fwcs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  fwcs_pkg::op_t     head_op,
  output logic              pop,
  fwcs_out_if.source        out_ch
);

  localparam int unsigned WW = fwcs_pkg::WORD_W;

  logic [WW-1:0]                 gbuf_r [3];
  logic                          out_valid_r, out_valid_nxt;
  logic [fwcs_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic [fwcs_pkg::ADDR_W-1:0]   addr_r, addr_nxt;
  logic [WW-1:0]                 w0_r, w0_nxt;
  logic [WW-1:0]                 w1_r, w1_nxt;
  logic [WW-1:0]                 w2_r, w2_nxt;
  logic [WW-1:0]                 w3_r, w3_nxt;
  logic                          fin_r, fin_nxt;
  logic                          is_gather;
  logic                          load;
  logic [WW-1:0]                 padded;

  assign is_gather = (head_op.kind == fwcs_pkg::OP_GATHER);
  assign pop  = head_valid && (is_gather || !out_valid_r || out_ch.ready);
  assign load = pop && !is_gather;

  // keep the low bytes that belong to the write, fill the rest
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      padded[8*b +: 8] = (2'(b) < head_op.aux) ? head_op.word[8*b +: 8]
                                                : fwcs_pkg::PAD_WORD[8*b +: 8];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    kind_nxt      = kind_r;
    addr_nxt      = addr_r;
    w0_nxt        = w0_r;
    w1_nxt        = w1_r;
    w2_nxt        = w2_r;
    w3_nxt        = w3_r;
    fin_nxt       = fin_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      addr_nxt      = head_op.addr;
      fin_nxt       = head_op.fin;
      w1_nxt        = '0;
      w2_nxt        = '0;
      w3_nxt        = '0;
      case (head_op.kind)
        fwcs_pkg::OP_QUAD: begin
          kind_nxt = fwcs_pkg::CMD_QUAD;
          w0_nxt   = gbuf_r[0];
          w1_nxt   = gbuf_r[1];
          w2_nxt   = gbuf_r[2];
          w3_nxt   = head_op.word;
        end
        fwcs_pkg::OP_ERROR: begin
          kind_nxt = fwcs_pkg::CMD_ERROR;
          w0_nxt   = '0;
        end
        fwcs_pkg::OP_PARTIAL: begin
          kind_nxt = fwcs_pkg::CMD_WORD;
          w0_nxt   = padded;
        end
        default: begin
          kind_nxt = fwcs_pkg::CMD_WORD;
          w0_nxt   = head_op.word;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_gather && head_op.aux != 2'd3) begin
      gbuf_r[head_op.aux] <= head_op.word;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    addr_r <= addr_nxt;
    w0_r   <= w0_nxt;
    w1_r   <= w1_nxt;
    w2_r   <= w2_nxt;
    w3_r   <= w3_nxt;
    fin_r  <= fin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.command_kind    = kind_r;
  assign out_ch.program_address = addr_r;
  assign out_ch.word_zero       = w0_r;
  assign out_ch.word_one        = w1_r;
  assign out_ch.word_two        = w2_r;
  assign out_ch.word_three      = w3_r;
  assign out_ch.final_command   = fin_r;

endmodule

>>> rtl/core/flash_write_command_splitter_core.sv
// flash_write_command_splitter_core: top level of the flash write command
// splitter. Depends on fwcs_pkg, fwcs_if, fwcs_front, fwcs_queue, fwcs_back.
//
// Usage:
//   in_ch carries source beats. A beat with first_word set opens a write and
//   carries start_address and byte_length as well as its source word.
//   out_ch carries program commands: word, quadword or misaligned error,
//   with final_command on the last command of a write.
//   Each accepted beat gives at most one command. Beats that only gather
//   quadword data, and beats outside a write, give none.
// Timing:
//   one beat per cycle sustained while out_ch.ready is high. A command passes
//   through the front/back queue and then the output register after its beat
//   is accepted. Rate is set by the single pass through the front classifier
//   and one queue pop per cycle in the back end.
// Reset: rst_n (synchronous, active low) clears the write state, the queue
//   and the output valid; no write is in progress afterwards.
// Stall: while out_ch.ready is low the output register holds, the queue
//   (two entries) fills, and in_ch.ready drops once it is full; gather
//   beats keep draining into the back end's buffer.
`timescale 1ns / 1ps

module flash_write_command_splitter_core #(
  parameter int unsigned MAX_WRITE_BYTES = fwcs_pkg::MAX_WRITE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fwcs_in_if.sink     in_ch,
  fwcs_out_if.source  out_ch
);

  logic           q_ready;
  logic           q_push;
  fwcs_pkg::op_t  q_op;
  logic           q_pop;
  logic           head_valid;
  fwcs_pkg::op_t  head_op;

  fwcs_front #(
    .MAX_WRITE_BYTES(MAX_WRITE_BYTES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_op    (q_op)
  );

  fwcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_op),
    .ready      (q_ready),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  fwcs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule

>>> verif/flash_write_command_splitter_core_tb.sv
// flash_write_command_splitter_core_tb: drives random and directed flash writes
// into the splitter and checks every program command against a predictor.
// Depends on fwcs_pkg, fwcs_if and flash_write_command_splitter_core.
`timescale 1ns / 1ps

module flash_write_command_splitter_core_tb;

  localparam int unsigned ADDR_W = fwcs_pkg::ADDR_W;
  localparam int unsigned LEN_W = fwcs_pkg::LEN_W;
  localparam int unsigned WORD_W = fwcs_pkg::WORD_W;
  localparam int unsigned KIND_W = fwcs_pkg::KIND_W;

  localparam int unsigned DIRECTED_BEATS = 25;
  localparam int unsigned RANDOM_BEATS = 550;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  typedef struct packed {
    logic              first;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] word;
  } src_beat_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w2;
    logic [WORD_W-1:0] w3;
    logic              fin;
  } command_t;

  class cmd_scoreboard;
    command_t          expected_cmds[$];
    logic [LEN_W-1:0]  bytes_remaining;
    logic [ADDR_W-1:0] next_addr;
    logic [WORD_W-1:0] gathered[3];
    int unsigned       gather_count;
    bit                write_open;
    bit                dropping;
    int unsigned       mismatches;

    function new();
      bytes_remaining = '0;
      next_addr = '0;
      gather_count = 0;
      write_open = 1'b0;
      dropping = 1'b0;
      mismatches = 0;
    endfunction

    // advance the write state by one accepted source beat
    function void absorb_beat(src_beat_t b);
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] mask;
      command_t          c;
      c = '0;
      if (b.first) begin
        len = (b.len > fwcs_pkg::MAX_WRITE_BYTES_DEF) ?
              LEN_W'(fwcs_pkg::MAX_WRITE_BYTES_DEF) : b.len;
        gather_count = 0;
        if (b.addr[1:0] != 2'b00) begin
          write_open = 1'b0;
          dropping = 1'b1;
          bytes_remaining = '0;
          c.kind = fwcs_pkg::CMD_ERROR;
          c.addr = b.addr;
          c.fin = 1'b1;
          expected_cmds.push_back(c);
          return;
        end
        dropping = 1'b0;
        next_addr = b.addr;
        bytes_remaining = len;
        write_open = (len != '0);
        if (!write_open) return;
      end else if (!write_open || dropping) begin
        return;
      end

      addr = next_addr;
      c.addr = addr;
      if (gather_count == 0 && addr[3:0] != 4'h0 && bytes_remaining >= 4) begin
        // lead-in word programs up to the 16-byte boundary
        bytes_remaining = bytes_remaining - LEN_W'(4);
        next_addr = addr + 32'd4;
        c.kind = fwcs_pkg::CMD_WORD;
        c.w0 = b.word;
      end else if (gather_count > 0 || bytes_remaining >= 16) begin
        if (gather_count < 3) begin
          gathered[gather_count] = b.word;
          gather_count++;
          return;
        end
        gather_count = 0;
        bytes_remaining = bytes_remaining - LEN_W'(16);
        next_addr = addr + 32'd16;
        c.kind = fwcs_pkg::CMD_QUAD;
        c.w0 = gathered[0];
        c.w1 = gathered[1];
        c.w2 = gathered[2];
        c.w3 = b.word;
      end else if (bytes_remaining >= 4) begin
        bytes_remaining = bytes_remaining - LEN_W'(4);
        next_addr = addr + 32'd4;
        c.kind = fwcs_pkg::CMD_WORD;
        c.w0 = b.word;
      end else begin
        // tail of 1..3 bytes, upper bytes padded
        mask = (32'h1 << (8 * bytes_remaining)) - 32'h1;
        c.kind = fwcs_pkg::CMD_WORD;
        c.w0 = (b.word & mask) | (fwcs_pkg::PAD_WORD & ~mask);
        bytes_remaining = '0;
      end
      c.fin = (bytes_remaining == '0);
      if (c.fin) write_open = 1'b0;
      expected_cmds.push_back(c);
    endfunction

    function void check_cmd(command_t got);
      command_t want;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected command kind %0d addr %h w %h %h %h %h fin %b",
                   $time, got.kind, got.addr, got.w0, got.w1, got.w2, got.w3, got.fin);
        return;
      end
      want = expected_cmds.pop_front();
      if (got.kind !== want.kind || got.addr !== want.addr || got.w0 !== want.w0 ||
          got.w1 !== want.w1 || got.w2 !== want.w2 || got.w3 !== want.w3 ||
          got.fin !== want.fin) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: command mismatch", $time);
          $display("  expected kind %0d addr %h w %h %h %h %h fin %b",
                   want.kind, want.addr, want.w0, want.w1, want.w2, want.w3, want.fin);
          $display("  actual   kind %0d addr %h w %h %h %h %h fin %b",
                   got.kind, got.addr, got.w0, got.w1, got.w2, got.w3, got.fin);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit steady;
  int unsigned beats_accepted;
  cmd_scoreboard sb;

  fwcs_in_if in_ch ();
  fwcs_out_if out_ch ();

  flash_write_command_splitter_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_400_000;
    $display("Simulation FAILED");
    $finish;
  end

  // command sink stalls at random outside the steady stretch
  always @(negedge clk) begin
    out_ch.ready = steady || ($urandom_range(99) >= 14);
  end

  // check commands first: a command never stems from a beat on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_cmd({out_ch.command_kind, out_ch.program_address, out_ch.word_zero,
                      out_ch.word_one, out_ch.word_two, out_ch.word_three,
                      out_ch.final_command});
      if (in_ch.valid && in_ch.ready)
        sb.absorb_beat({in_ch.first_word, in_ch.start_address, in_ch.byte_length,
                        in_ch.source_word});
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_beat(input logic first, input logic [ADDR_W-1:0] addr,
                           input logic [LEN_W-1:0] len, input logic [WORD_W-1:0] word);
    while (!steady && $urandom_range(99) < 14) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.first_word = first;
    in_ch.start_address = addr;
    in_ch.byte_length = len;
    in_ch.source_word = word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_accepted++;
    @(negedge clk);
  endtask

  task automatic send_write(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len,
                            input int unsigned count, input fill_t fill);
    logic [WORD_W-1:0] word;
    for (int unsigned i = 0; i < count; i++) begin
      case (fill)
        FILL_ZERO: word = '0;
        FILL_ONES: word = '1;
        default: word = $urandom;
      endcase
      if (i == 0)
        send_beat(1'b1, addr, len, word);
      else
        send_beat(1'b0, $urandom, LEN_W'($urandom), word);
    end
  endtask

  function automatic logic [ADDR_W-1:0] random_aligned();
    logic [ADDR_W-1:0] a;
    if ($urandom_range(99) < 6)
      a = 32'hFFFF_FF00 | ($urandom & 32'hFC);
    else
      a = $urandom & 32'hFFFF_FFFC;
    return a;
  endfunction

  function automatic logic [LEN_W-1:0] random_len();
    if ($urandom_range(99) < 85)
      return LEN_W'($urandom_range(64, 1));
    return LEN_W'($urandom_range(400, 65));
  endfunction

  initial begin
    int unsigned       pick;
    int unsigned       words;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    sb = new();
    steady = 1'b0;
    beats_accepted = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.first_word = 1'b0;
    in_ch.start_address = '0;
    in_ch.byte_length = '0;
    in_ch.source_word = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: stray beat, misaligned, zero length, partial tail, wrap,
    // saturated length abandoned mid-gather, lead-in words, field extremes
    send_beat(1'b0, $urandom, LEN_W'($urandom), $urandom);
    send_write(32'h0000_1001, 21'd8, 2, FILL_RANDOM);
    send_write(32'h0000_0100, 21'd0, 2, FILL_RANDOM);
    send_write(32'h0000_0004, 21'd7, 2, FILL_RANDOM);
    send_write(32'hFFFF_FFF0, 21'd21, 6, FILL_RANDOM);
    send_write(32'h0000_000C, 21'h1F_FFFF, 2, FILL_RANDOM);
    send_write(32'h0000_2000, 21'd2, 1, FILL_RANDOM);
    send_write(32'h0000_0008, 21'd16, 4, FILL_ONES);
    send_write(32'hFFFF_FFFC, 21'd4, 1, FILL_ZERO);
    send_write(32'h0000_0000, 21'd16, 4, FILL_ONES);

    while (beats_accepted < DIRECTED_BEATS + RANDOM_BEATS) begin
      steady = (beats_accepted >= 175 && beats_accepted < 325);
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = random_len();
        send_write(random_aligned(), len, (len + 3) / 4, FILL_RANDOM);
      end else if (pick < 80) begin
        addr = $urandom;
        addr[1:0] = 2'($urandom_range(3, 1));
        send_write(addr, LEN_W'($urandom), $urandom_range(4, 1), FILL_RANDOM);
      end else if (pick < 88) begin
        // broken write, abandoned by whatever comes next
        len = random_len();
        words = (len + 3) / 4;
        send_write(random_aligned(), len, $urandom_range(words, 1), FILL_RANDOM);
      end else if (pick < 93) begin
        if ($urandom_range(1))
          len = '0;
        else
          len = LEN_W'($urandom_range(2097151, fwcs_pkg::MAX_WRITE_BYTES_DEF));
        send_write(random_aligned(), len, $urandom_range(4, 1), FILL_RANDOM);
      end else begin
        repeat ($urandom_range(3, 1))
          send_beat(1'b0, $urandom, LEN_W'($urandom), $urandom);
      end
    end
    in_ch.valid = 1'b0;
    steady = 1'b0;

    while (sb.expected_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_cmds.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
